// ===== sv/rapst_pkg.sv =====
// Shared types and constants of the range-assign prefix-search tree.
// Holds the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rapst_pkg;

	localparam int CNT_W = 11;
	localparam int VAL_W = 32;
	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

	localparam logic CMD_ASSIGN = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	// Node address sources for the node memory.
	typedef enum logic [1:0] {
		NS_CUR   = 2'd0,
		NS_LEFT  = 2'd1,
		NS_RIGHT = 2'd2,
		NS_ROOT  = 2'd3
	} node_sel_t;

	// Write data sources for the node memory.
	typedef enum logic [1:0] {
		WD_FILL   = 2'd0,
		WD_UNFLAG = 2'd1,
		WD_COMB   = 2'd2,
		WD_ZERO   = 2'd3
	} wd_sel_t;

	// Span length fed to the multiplier.
	typedef enum logic [1:0] {
		LEN_FULL  = 2'd0,
		LEN_LEFT  = 2'd1,
		LEN_RIGHT = 2'd2
	} len_sel_t;

	// Moves of the current node pointer.
	typedef enum logic [2:0] {
		MV_NONE      = 3'd0,
		MV_LEFT      = 3'd1,
		MV_TOP_RIGHT = 3'd2,
		MV_POP       = 3'd3,
		MV_QSTEP     = 3'd4
	} move_t;

	typedef struct packed {
		logic      load_in;
		logic      clr_step;
		logic      rd_en;
		node_sel_t rd_sel;
		logic      wr_en;
		node_sel_t wr_sel;
		wd_sel_t   wd_sel;
		logic      mul_en;
		logic      use_pend;
		len_sel_t  len_sel;
		logic      latch_pend;
		logic      latch_left;
		logic      push;
		move_t     move;
		logic      mark_none;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_empty;
		logic disjoint;
		logic covered;
		logic leaf;
		logic flag;
		logic rd_le;
		logic top_phase;
		logic stack_empty;
		logic clr_last;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/range_assign_prefix_search_tree_top.sv =====
// Range-assign prefix-search tree over LEAVES signed elements.
//
// Input channel (in_valid/in_ready): command 0 assigns fill_value to the
// 1-based inclusive range range_first..range_last and returns nothing;
// command 1 returns on the output channel the 0-based index of the first
// element whose prefix sum exceeds query_height, capped at element_count.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes
// element_count; write it only while the block is idle.
// One item is worked on at a time. A query descends the tree level by level,
// first pushing a pending fill down to the children where one is set. An
// assign visits up to two partial nodes per level; an empty range is done
// in the cycle it is taken. All node traffic goes through the single node
// memory port pair, one read and one write per cycle.
// After reset the block clears the node memory, one node per cycle, all
// 2 * 2^clog2(LEAVES) nodes (2048 at LEAVES = 1024), before in_ready rises.
// Results sit in an output register; if the receiver stalls, the next
// item is still accepted and its query result waits until the transfer.
// Depends on rapst_pkg, rapst_ctrl and rapst_dpath.
`default_nettype none

module range_assign_prefix_search_tree_top import rapst_pkg::*; #(
	parameter int LEAVES = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    command,
	input  wire logic [CNT_W-1:0]        range_first,
	input  wire logic [CNT_W-1:0]        range_last,
	input  wire logic signed [VAL_W-1:0] fill_value,
	input  wire logic signed [VAL_W-1:0] query_height,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [CNT_W-1:0]             answer_index,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [CNT_W-1:0]        cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t st;

	assign cfg_ready = 1'b1;

	rapst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.out_ready(out_ready),
		.st       (st),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.cmd      (cmd)
	);

	rapst_dpath #(
		.LEAVES(LEAVES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.range_first (range_first),
		.range_last  (range_last),
		.fill_value  (fill_value),
		.query_height(query_height),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.st          (st),
		.answer_index(answer_index)
	);

	// The descent stack must be unwound whenever a new item can be taken.
	a_idle_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> st.stack_empty)
		else $error("stack not empty while ready for a new item");

	// An empty range is done in the cycle it is taken.
	a_empty_range_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_ASSIGN && range_first > range_last)
		|=> in_ready)
		else $error("empty range assign did not return to idle");

	// The block drops in_ready right after taking a query.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_QUERY) |=> !in_ready)
		else $error("ready right after a query transfer");

endmodule

`default_nettype wire

// ===== sv/rapst_ctrl.sv =====
// Controller of the range-assign prefix-search tree: one-hot sequencer
// that walks the tree and owns the input and output handshakes.
// Depends on rapst_pkg.
`default_nettype none

module rapst_ctrl import rapst_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire logic     command,
	input  wire logic     out_ready,
	input  wire dp_stat_t st,
	output logic          in_ready,
	output logic          out_valid,
	output dp_cmd_t       cmd
);

	typedef enum logic [20:0] {
		S_CLEAR  = 21'h000001,
		S_IDLE   = 21'h000002,
		S_A_ENTER= 21'h000004,
		S_A_MUL  = 21'h000008,
		S_A_FILL = 21'h000010,
		S_PD_CHK = 21'h000020,
		S_PD_ML  = 21'h000040,
		S_PD_WL  = 21'h000080,
		S_PD_MR  = 21'h000100,
		S_PD_WR  = 21'h000200,
		S_PD_CLR = 21'h000400,
		S_A_DOWN = 21'h000800,
		S_A_RET  = 21'h001000,
		S_A_UP1  = 21'h002000,
		S_A_UP2  = 21'h004000,
		S_A_UPW  = 21'h008000,
		S_Q_ROOT = 21'h010000,
		S_Q_LOOP = 21'h020000,
		S_Q_RDL  = 21'h040000,
		S_Q_DEC  = 21'h080000,
		S_OUT    = 21'h100000
	} state_t;

	state_t state_q, nxt;
	logic   query_q;
	logic   out_valid_q;

	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		nxt      = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.wr_en    = 1'b1;
				cmd.wd_sel   = WD_ZERO;
				cmd.clr_step = 1'b1;
				if (st.clr_last) nxt = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (command == CMD_QUERY) begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = NS_ROOT;
						nxt        = S_Q_ROOT;
					end else if (!st.in_empty) begin
						nxt = S_A_ENTER;
					end
				end
			end
			S_A_ENTER: begin
				if (st.disjoint) begin
					nxt = S_A_RET;
				end else if (st.covered) begin
					nxt = S_A_MUL;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = NS_CUR;
					nxt        = S_PD_CHK;
				end
			end
			S_A_MUL: begin
				cmd.mul_en  = 1'b1;
				cmd.len_sel = LEN_FULL;
				nxt         = S_A_FILL;
			end
			S_A_FILL: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = NS_CUR;
				cmd.wd_sel = WD_FILL;
				nxt        = S_A_RET;
			end
			S_PD_CHK: begin
				if (st.flag) begin
					cmd.latch_pend = 1'b1;
					nxt            = S_PD_ML;
				end else begin
					nxt = query_q ? S_Q_RDL : S_A_DOWN;
				end
			end
			S_PD_ML: begin
				cmd.mul_en   = 1'b1;
				cmd.use_pend = 1'b1;
				cmd.len_sel  = LEN_LEFT;
				nxt          = S_PD_WL;
			end
			S_PD_WL: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = NS_LEFT;
				cmd.wd_sel   = WD_FILL;
				cmd.use_pend = 1'b1;
				nxt          = S_PD_MR;
			end
			S_PD_MR: begin
				cmd.mul_en   = 1'b1;
				cmd.use_pend = 1'b1;
				cmd.len_sel  = LEN_RIGHT;
				nxt          = S_PD_WR;
			end
			S_PD_WR: begin
				cmd.wr_en    = 1'b1;
				cmd.wr_sel   = NS_RIGHT;
				cmd.wd_sel   = WD_FILL;
				cmd.use_pend = 1'b1;
				nxt          = S_PD_CLR;
			end
			S_PD_CLR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = NS_CUR;
				cmd.wd_sel = WD_UNFLAG;
				nxt        = query_q ? S_Q_RDL : S_A_DOWN;
			end
			S_A_DOWN: begin
				cmd.push = 1'b1;
				cmd.move = MV_LEFT;
				nxt      = S_A_ENTER;
			end
			S_A_RET: begin
				if (st.stack_empty) begin
					nxt = S_IDLE;
				end else if (!st.top_phase) begin
					cmd.move = MV_TOP_RIGHT;
					nxt      = S_A_ENTER;
				end else begin
					cmd.move = MV_POP;
					nxt      = S_A_UP1;
				end
			end
			S_A_UP1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = NS_LEFT;
				nxt        = S_A_UP2;
			end
			S_A_UP2: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_sel     = NS_RIGHT;
				cmd.latch_left = 1'b1;
				nxt            = S_A_UPW;
			end
			S_A_UPW: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = NS_CUR;
				cmd.wd_sel = WD_COMB;
				nxt        = S_A_RET;
			end
			S_Q_ROOT: begin
				if (st.rd_le) begin
					cmd.mark_none = 1'b1;
					nxt           = S_OUT;
				end else begin
					nxt = S_Q_LOOP;
				end
			end
			S_Q_LOOP: begin
				if (st.leaf) begin
					nxt = S_OUT;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = NS_CUR;
					nxt        = S_PD_CHK;
				end
			end
			S_Q_RDL: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = NS_LEFT;
				nxt        = S_Q_DEC;
			end
			S_Q_DEC: begin
				cmd.move = MV_QSTEP;
				nxt      = S_Q_LOOP;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					nxt          = S_IDLE;
				end
			end
			default: nxt = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			query_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.load_in) query_q <= (command == CMD_QUERY);
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rapst_dpath.sv =====
// Datapath of the range-assign prefix-search tree: node memory, descent
// stack, multiplier for span fills, and the query height and answer.
// Depends on rapst_pkg; driven by rapst_ctrl.
`default_nettype none

module rapst_dpath import rapst_pkg::*; #(
	parameter int LEAVES = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [CNT_W-1:0]        range_first,
	input  wire logic [CNT_W-1:0]        range_last,
	input  wire logic signed [VAL_W-1:0] fill_value,
	input  wire logic signed [VAL_W-1:0] query_height,
	input  wire logic                    cfg_we,
	input  wire logic [CNT_W-1:0]        cfg_data,
	input  wire dp_cmd_t                 cmd,
	output dp_stat_t                     st,
	output logic [CNT_W-1:0]             answer_index
);

	localparam int D   = $clog2(LEAVES);
	localparam int AW  = D + 1;
	localparam int NN  = 1 << AW;
	localparam int LW  = D + 1;
	localparam int SW  = VAL_W + 1 + D;
	localparam int HW  = SW + 1;
	localparam int CW  = (D + 2 > CNT_W + 1) ? D + 2 : CNT_W + 1;
	localparam int SD  = D + 1;
	localparam int SIW = $clog2(SD);
	localparam int KW  = (D > CNT_W) ? D : CNT_W;
	localparam logic [D-1:0] LAST_LEAF = D'(LEAVES - 1);

	typedef struct packed {
		logic signed [SW-1:0]    sum;
		logic signed [SW-1:0]    maxp;
		logic signed [VAL_W-1:0] pend;
		logic                    flag;
	} node_t;

	node_t mem [NN];
	node_t rd_q, left_q, wd;

	logic [AW-1:0] cur_v_q, clr_q, ra, wa, lc_v, rc_v;
	logic [D-1:0]  lo_q, hi_q, mid, top_lo, top_hi, top_mid;
	logic [AW-1:0] stk_v_q [SD];
	logic [D-1:0]  stk_lo_q [SD];
	logic [D-1:0]  stk_hi_q [SD];
	logic [SD-1:0] stk_ph_q;
	logic [SIW-1:0] lvl_q, top;

	logic signed [CW-1:0]    a_q, b_q, lo_x, hi_x;
	logic signed [VAL_W-1:0] val_q, pval_q, fval;
	logic signed [HW-1:0]    height_q;
	logic signed [SW-1:0]    prod_q, fval_x, cand;
	logic [LW-1:0]           len;
	logic signed [VAL_W+LW:0] prod_full;
	logic [CNT_W-1:0]        cnt_q, ans_q;
	logic                    none_q;
	logic [KW-1:0]           lo_k, cnt_k;

	assign answer_index = ans_q;

	assign top     = lvl_q - SIW'(1);
	assign top_lo  = stk_lo_q[top];
	assign top_hi  = stk_hi_q[top];
	assign mid     = lo_q + D'((hi_q - lo_q) >> 1);
	assign top_mid = top_lo + D'((top_hi - top_lo) >> 1);
	assign lc_v    = {cur_v_q[AW-2:0], 1'b0};
	assign rc_v    = {cur_v_q[AW-2:0], 1'b1};

	always_comb begin
		case (cmd.len_sel)
			LEN_FULL:  len = {1'b0, hi_q} - {1'b0, lo_q} + LW'(1);
			LEN_LEFT:  len = {1'b0, mid} - {1'b0, lo_q} + LW'(1);
			LEN_RIGHT: len = {1'b0, hi_q} - {1'b0, mid};
			default:   len = '0;
		endcase
	end

	assign fval      = cmd.use_pend ? pval_q : val_q;
	assign fval_x    = SW'(fval);
	assign prod_full = fval * $signed({1'b0, len});
	assign cand      = left_q.sum + rd_q.maxp;

	always_comb begin
		case (cmd.rd_sel)
			NS_CUR:   ra = cur_v_q;
			NS_LEFT:  ra = lc_v;
			NS_RIGHT: ra = rc_v;
			NS_ROOT:  ra = AW'(1);
			default:  ra = cur_v_q;
		endcase
		if (cmd.wd_sel == WD_ZERO) begin
			wa = clr_q;
		end else begin
			case (cmd.wr_sel)
				NS_LEFT:  wa = lc_v;
				NS_RIGHT: wa = rc_v;
				default:  wa = cur_v_q;
			endcase
		end
	end

	always_comb begin
		wd = '0;
		case (cmd.wd_sel)
			WD_FILL: begin
				wd.sum  = prod_q;
				wd.maxp = (prod_q > fval_x) ? prod_q : fval_x;
				wd.pend = fval;
				wd.flag = 1'b1;
			end
			WD_UNFLAG: begin
				wd      = rd_q;
				wd.flag = 1'b0;
			end
			WD_COMB: begin
				wd.sum  = left_q.sum + rd_q.sum;
				wd.maxp = (left_q.maxp > cand) ? left_q.maxp : cand;
			end
			default: wd = '0;
		endcase
	end

	assign lo_x  = CW'(lo_q);
	assign hi_x  = CW'(hi_q);
	assign lo_k  = KW'(lo_q);
	assign cnt_k = KW'(cnt_q);

	always_comb begin
		st             = '0;
		st.in_empty    = range_first > range_last;
		st.disjoint    = (b_q < lo_x) || (a_q > hi_x);
		st.covered     = (a_q <= lo_x) && (hi_x <= b_q);
		st.leaf        = lo_q == hi_q;
		st.flag        = rd_q.flag;
		st.rd_le       = HW'(rd_q.maxp) <= height_q;
		st.top_phase   = stk_ph_q[top];
		st.stack_empty = lvl_q == '0;
		st.clr_last    = &clr_q;
	end

	// Node memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[wa] <= wd;
		if (cmd.rd_en) rd_q <= mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
			clr_q <= '0;
			cnt_q <= CNT_RESET;
		end else begin
			if (cmd.clr_step) clr_q <= clr_q + AW'(1);
			if (cfg_we) cnt_q <= cfg_data;
			if (cmd.load_in) begin
				lvl_q <= '0;
			end else if (cmd.push) begin
				lvl_q <= lvl_q + SIW'(1);
			end else if (cmd.move == MV_POP) begin
				lvl_q <= top;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) prod_q <= prod_full[SW-1:0];
		if (cmd.latch_pend) pval_q <= rd_q.pend;
		if (cmd.latch_left) left_q <= rd_q;
		if (cmd.mark_none) none_q <= 1'b1;
		if (cmd.push) begin
			stk_v_q[lvl_q]  <= cur_v_q;
			stk_lo_q[lvl_q] <= lo_q;
			stk_hi_q[lvl_q] <= hi_q;
			stk_ph_q[lvl_q] <= 1'b0;
		end
		if (cmd.load_in) begin
			cur_v_q  <= AW'(1);
			lo_q     <= '0;
			hi_q     <= LAST_LEAF;
			a_q      <= CW'(range_first) - CW'(1);
			b_q      <= CW'(range_last) - CW'(1);
			val_q    <= fill_value;
			height_q <= HW'(query_height);
			none_q   <= 1'b0;
		end else begin
			case (cmd.move)
				MV_LEFT: begin
					cur_v_q <= lc_v;
					hi_q    <= mid;
				end
				MV_TOP_RIGHT: begin
					cur_v_q       <= {stk_v_q[top][AW-2:0], 1'b1};
					lo_q          <= top_mid + D'(1);
					hi_q          <= top_hi;
					stk_ph_q[top] <= 1'b1;
				end
				MV_POP: begin
					cur_v_q <= stk_v_q[top];
					lo_q    <= top_lo;
					hi_q    <= top_hi;
				end
				MV_QSTEP: begin
					// Skip the left half when no prefix in it exceeds the height.
					if (st.rd_le) begin
						height_q <= height_q - HW'(rd_q.sum);
						cur_v_q  <= rc_v;
						lo_q     <= mid + D'(1);
					end else begin
						cur_v_q <= lc_v;
						hi_q    <= mid;
					end
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			if (none_q) begin
				ans_q <= cnt_q;
			end else begin
				ans_q <= (lo_k < cnt_k) ? CNT_W'(lo_k) : cnt_q;
			end
		end
	end

endmodule

`default_nettype wire
